@@ design/held_key_event_filter_core_assert.svh @@
// Assertion macros shared by the held key event filter RTL.
// Each macro expects clk and arst_n in the including module's scope.
`ifndef HELD_KEY_EVENT_FILTER_CORE_ASSERT_SVH
`define HELD_KEY_EVENT_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, muted while reset is asserted.
`define HKEF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, muted while reset is asserted.
`define HKEF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/hkef_pkg.sv @@
// Shared types and constants for the held key event filter.
// No dependencies; imported by every RTL module of the block.
`timescale 1ns / 1ps

package hkef_pkg;

	localparam int HELD_DEPTH_DEF = 16;
	localparam int KEY_CODES_DEF  = 256;
	localparam int CODE_W         = 8;
	localparam int CODE_SPACE     = 1 << CODE_W;
	localparam int QUEUE_DEPTH    = 2;

	typedef enum logic [2:0] {
		VD_UNBOUND   = 3'd0,
		VD_BOUND     = 3'd1,
		VD_MODIFIERS = 3'd2,
		VD_HOTKEY    = 3'd3,
		VD_IGNORE    = 3'd4
	} verdict_t;

	typedef enum logic [1:0] {
		OP_PUSH,
		OP_FLUSH,
		OP_RELEASE
	} op_t;

	// One command word from front to back.
	typedef struct packed {
		op_t               op;
		logic [CODE_W-1:0] code;
		logic              press;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_FLUSH,
		BK_COMPACT
	} bk_state_t;

endpackage

@@ design/held_key_event_filter_core.sv @@
// Top level of the held key event filter: front end, command queue, back end.
// Depends on hkef_pkg, hkef_front, hkef_queue, hkef_back.
`timescale 1ns / 1ps
//
// Channel   | Handshake               | Words
// ----------+-------------------------+-------------------------------------
// input     | start & !busy           | key_code[7:0], press, verdict[2:0]
// result    | fwd_strobe, one cycle   | fwd_code[7:0], fwd_press, last_of_run
//
// A bound press is appended to the held buffer, if it has room, without a walk.
// A release walks the held buffer through its single read port, dropping held
//   copies of its code; if nothing was dropped the release is strobed in the
//   cycle after the walk.
// A flush walks the same way, one flushed word per cycle, the current word
//   last.
// Reset: arst_n clears all control and the held count; the held buffer keeps
//   no reset and needs no clearing pass, only entries below the count are read.
// Stalls: busy rises only while the two-word command queue is full, i.e.
//   while the back end is still walking the buffer; results are never held.

module held_key_event_filter_core #(
	parameter int HELD_DEPTH = hkef_pkg::HELD_DEPTH_DEF,
	parameter int KEY_CODES  = hkef_pkg::KEY_CODES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [hkef_pkg::CODE_W-1:0] key_code,
	input  logic                        press,
	input  logic [2:0]                  verdict,
	output logic                        fwd_strobe,
	output logic [hkef_pkg::CODE_W-1:0] fwd_code,
	output logic                        fwd_press,
	output logic                        last_of_run
);
	import hkef_pkg::*;

	// command words from the classifier into the queue
	logic q_push;
	cmd_t q_in_word;
	logic q_full;

	// command words from the queue into the sequencer
	logic q_pop;
	cmd_t q_out_word;
	logic q_not_empty;

	// classifier: handles the handshake and the modifiers-only flag
	hkef_front #(
		.KEY_CODES(KEY_CODES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.key_code (key_code),
		.press    (press),
		.verdict  (verdict),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_word   (q_in_word)
	);

	// decoupling queue so the front keeps taking words during a flush
	hkef_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_word (q_in_word),
		.full      (q_full),
		.pop       (q_pop),
		.pop_word  (q_out_word),
		.not_empty (q_not_empty)
	);

	// sequencer: held buffer, flush and compaction
	hkef_back #(
		.HELD_DEPTH(HELD_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_not_empty),
		.q_word      (q_out_word),
		.q_pop       (q_pop),
		.fwd_strobe  (fwd_strobe),
		.fwd_code    (fwd_code),
		.fwd_press   (fwd_press),
		.last_of_run (last_of_run)
	);

endmodule

@@ design/hkef_front.sv @@
// Front end: takes input words, classifies them into back-end commands.
// Depends on hkef_pkg. Owns the modifiers-only flag.
`timescale 1ns / 1ps

module hkef_front #(
	parameter int KEY_CODES = hkef_pkg::KEY_CODES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [hkef_pkg::CODE_W-1:0] key_code,
	input  logic                       press,
	input  logic [2:0]                 verdict,
	input  logic                       q_full,
	output logic                       q_push,
	output hkef_pkg::cmd_t             q_word
);
	import hkef_pkg::*;

	logic only_mod_q;
	logic only_mod_d;
	logic accept;
	logic in_range;
	logic inert;

	assign busy     = q_full;
	assign accept   = start && !q_full;
	assign in_range = (KEY_CODES >= CODE_SPACE) || (32'(key_code) < KEY_CODES);
	// hotkey, ignore and unused verdicts do nothing; out-of-range codes count as unbound
	assign inert    = in_range && (verdict >= 3'(VD_HOTKEY));

	always_comb begin
		q_push           = 1'b0;
		q_word.op        = OP_PUSH;
		q_word.code      = key_code;
		q_word.press     = press;
		only_mod_d       = only_mod_q;
		if (accept && !inert) begin
			q_push = 1'b1;
			if (press) begin
				only_mod_d = in_range && (verdict == VD_MODIFIERS);
				if (!in_range || verdict == VD_UNBOUND) begin
					q_word.op = OP_FLUSH;
				end else begin
					q_word.op = OP_PUSH;
				end
			end else if (only_mod_q) begin
				only_mod_d = 1'b0;
				q_word.op  = OP_FLUSH;
			end else begin
				q_word.op = OP_RELEASE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			only_mod_q <= 1'b0;
		end else begin
			only_mod_q <= only_mod_d;
		end
	end

endmodule

@@ design/hkef_queue.sv @@
// Short command queue between front and back end.
// Depends on hkef_pkg for the command word type and depth.
`timescale 1ns / 1ps

module hkef_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hkef_pkg::cmd_t push_word,
	output logic           full,
	input  logic           pop,
	output hkef_pkg::cmd_t pop_word,
	output logic           not_empty
);
	import hkef_pkg::*;

	localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	cmd_t           slot_q [QUEUE_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] fill_q;

	function automatic logic [QAW-1:0] bump(input logic [QAW-1:0] p);
		if (p == QAW'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + QAW'(1);
	endfunction

	assign full      = (fill_q == QCW'(QUEUE_DEPTH));
	assign not_empty = (fill_q != '0);
	assign pop_word  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + QCW'(1);
				2'b01:   fill_q <= fill_q - QCW'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

@@ design/hkef_back.sv @@
// Back end: held-press buffer, flush and compaction sequencer.
// Depends on hkef_pkg and held_key_event_filter_core_assert.svh.
`timescale 1ns / 1ps
`include "held_key_event_filter_core_assert.svh"

module hkef_back #(
	parameter int HELD_DEPTH = hkef_pkg::HELD_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  hkef_pkg::cmd_t              q_word,
	output logic                        q_pop,
	output logic                        fwd_strobe,
	output logic [hkef_pkg::CODE_W-1:0] fwd_code,
	output logic                        fwd_press,
	output logic                        last_of_run
);
	import hkef_pkg::*;

	localparam int CW = $clog2(HELD_DEPTH + 1);
	localparam int AW = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;

	bk_state_t         state_q, state_d;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     rptr_q;
	logic [CW-1:0]     wptr_q;
	logic              dv_q;
	cmd_t              cmd_q;

	logic [CODE_W-1:0] mem [HELD_DEPTH];
	logic [CODE_W-1:0] rdata_q;

	logic              seq_done;
	logic              issue;
	logic              push_ok;
	logic              comp_wr;
	logic              flush_end;
	logic              comp_end;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [CODE_W-1:0] mem_wdata;
	logic              emit;
	logic [CODE_W-1:0] emit_code;
	logic              emit_press;
	logic              emit_last;

	assign q_pop    = (state_q == BK_IDLE) && q_valid;
	assign seq_done = !dv_q && (rptr_q == count_q);

	// next state; every release walks the buffer to find held copies of its code
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_pop) begin
					case (q_word.op)
						OP_FLUSH:   state_d = BK_FLUSH;
						OP_RELEASE: state_d = BK_COMPACT;
						default:    state_d = BK_IDLE;
					endcase
				end
			end
			BK_FLUSH:   if (seq_done) state_d = BK_IDLE;
			BK_COMPACT: if (seq_done) state_d = BK_IDLE;
			default:    state_d = BK_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		issue      = 1'b0;
		push_ok    = 1'b0;
		comp_wr    = 1'b0;
		flush_end  = 1'b0;
		comp_end   = 1'b0;
		emit       = 1'b0;
		emit_code  = cmd_q.code;
		emit_press = cmd_q.press;
		emit_last  = 1'b1;
		case (state_q)
			BK_IDLE: begin
				if (q_pop) begin
					push_ok = (q_word.op == OP_PUSH) && (count_q < CW'(HELD_DEPTH));
				end
			end
			BK_FLUSH: begin
				issue = (rptr_q < count_q);
				if (dv_q) begin
					emit       = 1'b1;
					emit_code  = rdata_q;
					emit_press = 1'b1;
					emit_last  = 1'b0;
				end else if (seq_done) begin
					emit      = 1'b1;
					flush_end = 1'b1;
				end
			end
			BK_COMPACT: begin
				issue    = (rptr_q < count_q);
				comp_wr  = dv_q && (rdata_q != cmd_q.code);
				comp_end = seq_done;
				// nothing dropped: the key was not held, so the release goes out
				if (seq_done && wptr_q == count_q) begin
					emit       = 1'b1;
					emit_press = 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign mem_we    = push_ok || comp_wr;
	assign mem_waddr = comp_wr ? wptr_q[AW-1:0] : count_q[AW-1:0];
	assign mem_wdata = comp_wr ? rdata_q : q_word.code;

	// held-code buffer, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (issue) begin
			rdata_q <= mem[rptr_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_word;
		end
		if (emit) begin
			fwd_code    <= emit_code;
			fwd_press   <= emit_press;
			last_of_run <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			count_q    <= '0;
			rptr_q     <= '0;
			wptr_q     <= '0;
			dv_q       <= 1'b0;
			fwd_strobe <= 1'b0;
		end else begin
			state_q    <= state_d;
			dv_q       <= issue;
			fwd_strobe <= emit;
			if (q_pop) begin
				rptr_q <= '0;
				wptr_q <= '0;
			end else begin
				if (issue) begin
					rptr_q <= rptr_q + CW'(1);
				end
				if (comp_wr) begin
					wptr_q <= wptr_q + CW'(1);
				end
			end
			if (push_ok) begin
				count_q <= count_q + CW'(1);
			end else if (flush_end) begin
				count_q <= '0;
			end else if (comp_end) begin
				count_q <= wptr_q;
			end
		end
	end

	`HKEF_ASSERT_NOW(a_pop_only_idle, q_pop, state_q == BK_IDLE, "pop outside idle")
	`HKEF_ASSERT_NOW(a_wr_behind_rd, dv_q && state_q == BK_COMPACT, wptr_q < rptr_q,
		"compaction write caught up with read")
	`HKEF_ASSERT_NEXT(a_flush_empties, flush_end,
		count_q == '0 && fwd_strobe && last_of_run, "flush left entries")
	`HKEF_ASSERT_NEXT(a_drop_shrinks, comp_end,
		count_q <= $past(count_q) && (!fwd_strobe || !fwd_press),
		"drop grew buffer or forwarded a press")

endmodule

@@ verif/tb_held_key_event_filter_core.sv @@
// Self-checking testbench for held_key_event_filter_core: directed and random key events,
// predicted results compared word by word against the forwarded stream.
// Depends on hkef_pkg and the held_key_event_filter_core RTL.
`timescale 1ns / 1ps

module tb_held_key_event_filter_core;
	import hkef_pkg::*;

	localparam int          LIMIT_NS     = 5_000_000;
	localparam int          TAIL_CYCLES  = 2 * (HELD_DEPTH_DEF + 4);
	localparam int          MAX_REPORTS  = 10;
	localparam logic [2:0]  VD_UNUSED_LO = 3'd5;
	localparam logic [2:0]  VD_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              pr;
		logic              last;
	} fwd_word_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [CODE_W-1:0] key_code = '0;
	logic              press = 1'b0;
	logic [2:0]        verdict = '0;
	logic              fwd_strobe;
	logic [CODE_W-1:0] fwd_code;
	logic              fwd_press;
	logic              last_of_run;

	// predictor state
	logic [CODE_W-1:0] held_codes [HELD_DEPTH_DEF];
	int                held_cnt = 0;
	bit                held_mask [KEY_CODES_DEF];
	bit                mod_only = 1'b0;

	fwd_word_t fwd_q [$];
	fwd_word_t seen;
	int        err_cnt = 0;
	int        sent_words = 0;
	bit        gaps_on = 1'b1;

	held_key_event_filter_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.key_code   (key_code),
		.press      (press),
		.verdict    (verdict),
		.fwd_strobe (fwd_strobe),
		.fwd_code   (fwd_code),
		.fwd_press  (fwd_press),
		.last_of_run(last_of_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Work out the forwarded words caused by one accepted event.
	function automatic void predict_event(input logic [CODE_W-1:0] code, input logic pr,
			input logic [2:0] vd);
		logic [2:0] eff;
		bit         in_range;
		bit         do_flush;
		bit         fwd_cur;
		int         r;
		int         w;
		in_range = int'(code) < KEY_CODES_DEF;
		eff = vd;
		do_flush = 1'b0;
		fwd_cur = 1'b0;
		if (in_range) begin
			if (vd >= VD_HOTKEY)
				return;
		end else begin
			eff = VD_UNBOUND;
		end
		if (pr) begin
			mod_only = (eff == VD_MODIFIERS);
			if (eff == VD_UNBOUND) begin
				do_flush = 1'b1;
				fwd_cur = 1'b1;
			end else if (held_cnt < HELD_DEPTH_DEF) begin
				held_codes[held_cnt] = code;
				held_cnt++;
				held_mask[code] = 1'b1;
			end
		end else if (mod_only) begin
			mod_only = 1'b0;
			do_flush = 1'b1;
			fwd_cur = 1'b1;
		end else if (in_range && held_mask[code]) begin
			// drop every held copy of this code, keep the rest in order
			w = 0;
			for (r = 0; r < held_cnt; r++) begin
				if (held_codes[r] != code) begin
					held_codes[w] = held_codes[r];
					w++;
				end
			end
			held_cnt = w;
			held_mask[code] = 1'b0;
		end else begin
			fwd_cur = 1'b1;
		end
		if (do_flush) begin
			for (r = 0; r < held_cnt; r++)
				fwd_q.push_back('{code: held_codes[r], pr: 1'b1, last: 1'b0});
			held_cnt = 0;
			foreach (held_mask[i])
				held_mask[i] = 1'b0;
		end
		// the current event is always the final word of its run
		if (fwd_cur)
			fwd_q.push_back('{code: code, pr: pr, last: 1'b1});
	endfunction

	task automatic note_mismatch(input string what, input int expv, input int actv);
		err_cnt++;
		if (err_cnt <= MAX_REPORTS)
			$display("[%0t] %s: expected %0h, got %0h", $realtime, what, expv, actv);
	endtask

	// Results cannot be held off: every strobe is checked at the edge ending it.
	always @(posedge clk) begin
		if (arst_n && fwd_strobe) begin
			if (fwd_q.size() == 0) begin
				note_mismatch("unexpected word, code", 0, fwd_code);
			end else begin
				seen = fwd_q.pop_front();
				if (fwd_code !== seen.code)
					note_mismatch("fwd_code", seen.code, fwd_code);
				if (fwd_press !== seen.pr)
					note_mismatch("fwd_press", seen.pr, fwd_press);
				if (last_of_run !== seen.last)
					note_mismatch("last_of_run", seen.last, last_of_run);
			end
		end
	end

	task automatic rest(input int cycles);
		start <= 1'b0;
		key_code <= CODE_W'($urandom_range(0, 255));
		press <= 1'($urandom_range(0, 1));
		verdict <= 3'($urandom_range(0, 7));
		repeat (cycles) @(posedge clk);
	endtask

	// Present one event and hold it until accepted; start stays high for a following word.
	task automatic send_word(input logic [CODE_W-1:0] code, input logic pr,
			input logic [2:0] vd);
		start <= 1'b1;
		key_code <= code;
		press <= pr;
		verdict <= vd;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_event(code, pr, vd);
		sent_words++;
		if (gaps_on && $urandom_range(0, 2) == 0)
			rest($urandom_range(1, 19));
	endtask

	// Stop sending until every expected word has come, then let the back end settle.
	task automatic settle_idle();
		start <= 1'b0;
		@(posedge clk);
		while (fwd_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic test_plain_events();
		logic [2:0] v;
		send_word(8'h00, 1'b1, VD_UNBOUND);
		send_word(8'hFF, 1'b1, VD_UNBOUND);
		send_word(8'hFF, 1'b0, VD_UNBOUND);
		send_word(8'h00, 1'b0, VD_BOUND);
		send_word(8'h5A, 1'b1, VD_HOTKEY);
		send_word(8'h5A, 1'b0, VD_IGNORE);
		for (v = VD_UNUSED_LO; v != 3'(VD_UNUSED_HI + 1'b1); v++)
			send_word(8'hA5, v[0], v);
		settle_idle();
	endtask

	task automatic test_flush_paths();
		// release after a modifier press flushes, then forwards the release
		send_word(8'h10, 1'b1, VD_BOUND);
		send_word(8'h20, 1'b1, VD_MODIFIERS);
		send_word(8'h30, 1'b0, VD_BOUND);
		// unbound press flushes, then forwards the press
		send_word(8'h81, 1'b1, VD_BOUND);
		send_word(8'h7E, 1'b1, VD_UNBOUND);
		settle_idle();
	endtask

	task automatic test_drop_marked();
		send_word(8'h41, 1'b1, VD_BOUND);
		send_word(8'h42, 1'b1, VD_BOUND);
		send_word(8'h41, 1'b1, VD_BOUND);
		send_word(8'h41, 1'b0, VD_BOUND);
		send_word(8'h43, 1'b1, VD_HOTKEY);
		send_word(8'hFE, 1'b1, VD_UNBOUND);
		settle_idle();
	endtask

	// Overfill the buffer, then a modifier press on a full buffer and its release: 20 words.
	task automatic test_buffer_full();
		repeat (HELD_DEPTH_DEF + 2)
			send_word(CODE_W'($urandom_range(0, 255)), 1'b1, VD_BOUND);
		send_word(CODE_W'($urandom_range(0, 255)), 1'b1, VD_MODIFIERS);
		send_word(CODE_W'($urandom_range(0, 255)), 1'b0, VD_BOUND);
		settle_idle();
	endtask

	task automatic hold_sequence();
		logic [CODE_W-1:0] pool [3];
		int                n;
		int                pick;
		foreach (pool[i])
			pool[i] = CODE_W'($urandom_range(0, 255));
		n = $urandom_range(1, 8);
		repeat (n) begin
			pick = $urandom_range(0, 9);
			if (pick < 6)
				send_word(pool[$urandom_range(0, 2)], 1'b1, VD_BOUND);
			else if (pick < 7)
				send_word(pool[$urandom_range(0, 2)], 1'b1, VD_MODIFIERS);
			else if (pick < 9)
				send_word(pool[$urandom_range(0, 2)], 1'b0, 3'($urandom_range(0, 2)));
			else
				send_word(CODE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					3'($urandom_range(VD_HOTKEY, VD_UNUSED_HI)));
		end
		case ($urandom_range(0, 3))
			0: begin
				send_word(CODE_W'($urandom_range(0, 255)), 1'b1, VD_UNBOUND);
			end
			1: begin
				send_word(pool[$urandom_range(0, 2)], 1'b1, VD_MODIFIERS);
				send_word(pool[$urandom_range(0, 2)], 1'b0, VD_MODIFIERS);
			end
			2: begin
				send_word(CODE_W'($urandom_range(0, 255)), 1'b0, VD_BOUND);
			end
			default: begin
			end
		endcase
	endtask

	task automatic fill_sequence();
		repeat ($urandom_range(HELD_DEPTH_DEF - 2, HELD_DEPTH_DEF + 4))
			send_word(CODE_W'($urandom_range(0, 255)), 1'b1, VD_BOUND);
		send_word(CODE_W'($urandom_range(0, 255)), 1'b1, VD_UNBOUND);
	endtask

	task automatic random_mix(input int goal);
		int pick;
		while (sent_words < goal) begin
			if (goal > 0 && !gaps_on && sent_words >= goal)
				break;
			pick = $urandom_range(0, 9);
			if (pick < 6)
				hold_sequence();
			else if (pick < 7)
				fill_sequence();
			else
				repeat ($urandom_range(1, 3))
					send_word(CODE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
						3'($urandom_range(0, 7)));
		end
	endtask

	task automatic test_random_gapped();
		while (sent_words < 230) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			random_mix(sent_words + 10);
		end
		gaps_on = 1'b1;
		settle_idle();
	endtask

	task automatic test_back_to_back();
		gaps_on = 1'b0;
		random_mix(280);
		settle_idle();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_plain_events();
		test_flush_paths();
		test_drop_marked();
		test_buffer_full();
		test_random_gapped();
		test_back_to_back();
		if (err_cnt == 0 && fwd_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
